/* src/sacsp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacsp_pkg
// Shared types and constants for the serial angle command to servo pulse block.
// ----------------------------------------------------------------------------
package sacsp_pkg;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_LONG  = 2'd1;
  localparam logic [1:0] ST_NAN   = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX = 1'd1;

  // Character codes
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Number limits
  localparam logic [18:0] MAG_LIMIT = 19'd32000;
  localparam logic [14:0] ANGLE_TOP = 15'd180;

  // Reset values
  localparam logic [14:0] PULSE_MIN_RST = 15'd600;
  localparam logic [14:0] PULSE_MAX_RST = 15'd2400;
  localparam logic [15:0] HELD_RST      = 16'd1800;

  // floor(p / 180) == (p * RECIP_MUL) >> RECIP_SHIFT for every p below 2^23
  localparam logic [23:0] RECIP_MUL   = 24'd11930465;
  localparam int unsigned RECIP_SHIFT = 31;

  // Scan step control toward the parser
  typedef struct packed {
    logic clr;
    logic step;
    logic first;
  } parse_ctl_t;

  // Parser state seen by the sequencer
  typedef struct packed {
    logic        nan;
    logic        neg;
    logic        has_digit;
    logic [14:0] mag;
  } parse_res_t;

  // Angle unit completion
  typedef struct packed {
    logic        done;
    logic [15:0] compare;
  } ang_res_t;

endpackage

/* src/sacsp_line_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacsp_line_mem
// Line character store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sacsp_line_mem #(
  parameter int unsigned DEPTH  = 7,
  parameter int unsigned ADDR_W = 3
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem_r [DEPTH];
  logic [7:0] rd_data_r;

  // Store a character
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* src/sacsp_parse.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacsp_parse
// Decimal scanner: consumes one line character per step, tracks sign,
// magnitude and a sticky not-a-number mark.
// ----------------------------------------------------------------------------
module sacsp_parse (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sacsp_pkg::parse_ctl_t ctl,
  input  logic [7:0]            char_in,
  output sacsp_pkg::parse_res_t res
);

  logic        nan_r;
  logic        neg_r;
  logic        dig_r;
  logic [14:0] mag_r;
  logic        is_digit;
  logic [3:0]  digit;
  logic [18:0] mag_ext;

  // Decode the digit and form mag * 10 + digit
  assign is_digit = (char_in >= sacsp_pkg::CH_ZERO) && (char_in <= sacsp_pkg::CH_NINE);
  assign digit    = 4'(char_in - sacsp_pkg::CH_ZERO);
  assign mag_ext  = {1'b0, mag_r, 3'b000} + {3'b000, mag_r, 1'b0} + {15'd0, digit};

  // Advance one character; freeze once the line is rejected
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nan_r <= 1'b0;
      neg_r <= 1'b0;
      dig_r <= 1'b0;
      mag_r <= '0;
    end else if (ctl.clr) begin
      nan_r <= 1'b0;
      neg_r <= 1'b0;
      dig_r <= 1'b0;
      mag_r <= '0;
    end else if (ctl.step && !nan_r) begin
      priority if (ctl.first && (char_in == sacsp_pkg::CH_MINUS)) begin
        neg_r <= 1'b1;
      end else if (ctl.first && (char_in == sacsp_pkg::CH_PLUS)) begin
        neg_r <= 1'b0;
      end else if (is_digit) begin
        if (mag_ext > sacsp_pkg::MAG_LIMIT) begin
          nan_r <= 1'b1;
        end else begin
          mag_r <= mag_ext[14:0];
          dig_r <= 1'b1;
        end
      end else begin
        nan_r <= 1'b1;
      end
    end
  end

  assign res.nan       = nan_r;
  assign res.neg       = neg_r;
  assign res.has_digit = dig_r;
  assign res.mag       = mag_r;

endmodule

/* src/sacsp_angle.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacsp_angle
// Three-stage pipeline: 2 * (min + (max - min) * angle / 180).
// ----------------------------------------------------------------------------
module sacsp_angle (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [7:0]          angle,
  input  logic [14:0]         pulse_min,
  input  logic [14:0]         pulse_max,
  output sacsp_pkg::ang_res_t res
);

  logic        v1_r;
  logic        v2_r;
  logic        v3_r;
  logic [15:0] diff;
  logic [22:0] prod_r;
  logic [46:0] scaled;
  logic [14:0] quot_r;
  logic [15:0] us;
  logic [15:0] cmp_r;

  // Span; the stage 1 product is forced to zero when the limits are reversed
  assign diff = {1'b0, pulse_max} - {1'b0, pulse_min};

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Stage 1: span times angle
  always_ff @(posedge clk) begin
    if (start) begin
      prod_r <= diff[15] ? 23'd0 : (23'(diff[14:0]) * 23'(angle));
    end
  end

  // Stage 2: divide by 180 through the reciprocal
  assign scaled = 47'(prod_r) * 47'(sacsp_pkg::RECIP_MUL);

  always_ff @(posedge clk) begin
    if (v1_r) begin
      quot_r <= scaled[sacsp_pkg::RECIP_SHIFT +: 15];
    end
  end

  // Stage 3: add offset and scale to half microseconds
  assign us = {1'b0, pulse_min} + {1'b0, quot_r};

  always_ff @(posedge clk) begin
    if (v2_r) begin
      cmp_r <= {us[14:0], 1'b0};
    end
  end

  assign res.done    = v3_r;
  assign res.compare = cmp_r;

endmodule

/* src/serial_angle_command_to_servo_pulse.sv */
`timescale 1ns / 1ps
// An ordinary character or erase is taken back to back while the block is idle.
// A line end runs scan, evaluate, angle pipeline and done when the angle is accepted,
// scan, evaluate and done when rejected as a number, only done when the line was too long.
// Throughput: line characters are scanned one per cycle through the store's read port.
// Reset: empty line, overflow clear, compare 1800, limits 600 and 2400 us.
// ----------------------------------------------------------------------------
// serial_angle_command_to_servo_pulse
// Gathers serial characters into a line, parses a decimal angle at line end
// and updates the held servo PWM compare value.
// ----------------------------------------------------------------------------
module serial_angle_command_to_servo_pulse #(
  parameter int unsigned LINE_SLOTS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_char_code,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          out_line_status,
  output logic signed [15:0]                  out_parsed_value,
  output logic [15:0]                         out_compare_value,
  input  logic                                cfg_we,
  input  logic [sacsp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [14:0]                         cfg_wdata
);

  localparam int unsigned DEPTH  = LINE_SLOTS - 1;
  localparam int unsigned LEN_W  = $clog2(LINE_SLOTS);
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_CALC = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic               ovf_r, ovf_nxt;
  logic [LEN_W-1:0]   pos_r, pos_nxt;
  logic [1:0]         stat_r, stat_nxt;
  logic signed [15:0] val_r, val_nxt;
  logic [15:0]        held_r, held_nxt;
  logic [14:0]        pulse_min_r;
  logic [14:0]        pulse_max_r;
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_status_r;
  logic signed [15:0] out_value_r;
  logic [15:0]        out_compare_r;

  logic                  in_acc;
  logic                  is_end;
  logic                  is_erase;
  logic [LEN_W-1:0]      pos_plus;
  logic                  mem_we;
  logic [ADDR_W-1:0]     rd_addr;
  logic [7:0]            rd_data;
  logic                  load;
  logic                  ang_start;
  logic signed [15:0]    signed_val;
  logic                  bad_range;
  sacsp_pkg::parse_ctl_t pctl;
  sacsp_pkg::parse_res_t pres;
  sacsp_pkg::ang_res_t   ares;

  // Line store
  sacsp_line_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .wr_addr (len_r[ADDR_W-1:0]),
    .wr_data (in_char_code),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Number scanner
  sacsp_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (pctl),
    .char_in (rd_data),
    .res     (pres)
  );

  // Angle to compare pipeline
  sacsp_angle u_angle (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (ang_start),
    .angle     (pres.mag[7:0]),
    .pulse_min (pulse_min_r),
    .pulse_max (pulse_max_r),
    .res       (ares)
  );

  // Decode the request
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign is_end   = (in_char_code == sacsp_pkg::CH_CR) || (in_char_code == sacsp_pkg::CH_LF);
  assign is_erase = (in_char_code == sacsp_pkg::CH_BS) || (in_char_code == sacsp_pkg::CH_DEL);
  assign pos_plus = pos_r + 1'b1;

  // Signed value and range check of the parsed number
  assign signed_val = pres.neg ? -$signed({1'b0, pres.mag}) : $signed({1'b0, pres.mag});
  assign bad_range  = (pres.neg && (pres.mag != 15'd0)) || (pres.mag > sacsp_pkg::ANGLE_TOP);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    ovf_nxt       = ovf_r;
    pos_nxt       = pos_r;
    stat_nxt      = stat_r;
    val_nxt       = val_r;
    held_nxt      = held_r;
    out_valid_nxt = out_valid_r && out_stall;
    load          = 1'b0;
    mem_we        = 1'b0;
    rd_addr       = '0;
    pctl          = '0;
    ang_start     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          priority if (is_end) begin
            if (len_r != '0) begin
              if (ovf_r) begin
                stat_nxt  = sacsp_pkg::ST_LONG;
                val_nxt   = '0;
                state_nxt = S_DONE;
              end else begin
                pctl.clr  = 1'b1;
                pos_nxt   = '0;
                state_nxt = S_SCAN;
              end
            end
          end else if (is_erase) begin
            if (len_r != '0) begin
              len_nxt = len_r - 1'b1;
            end
          end else if (len_r < LEN_FULL) begin
            mem_we  = 1'b1;
            len_nxt = len_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
      S_SCAN: begin
        pctl.step  = 1'b1;
        pctl.first = (pos_r == '0);
        if (pos_plus < len_r) begin
          rd_addr = pos_plus[ADDR_W-1:0];
          pos_nxt = pos_plus;
        end else begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        priority if (pres.nan || !pres.has_digit) begin
          stat_nxt  = sacsp_pkg::ST_NAN;
          val_nxt   = '0;
          state_nxt = S_DONE;
        end else if (bad_range) begin
          stat_nxt  = sacsp_pkg::ST_RANGE;
          val_nxt   = signed_val;
          state_nxt = S_DONE;
        end else begin
          stat_nxt  = sacsp_pkg::ST_OK;
          val_nxt   = signed_val;
          ang_start = 1'b1;
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        if (ares.done) begin
          held_nxt  = ares.compare;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          load          = 1'b1;
          out_valid_nxt = 1'b1;
          len_nxt       = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and held state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      ovf_r       <= 1'b0;
      held_r      <= sacsp_pkg::HELD_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      ovf_r       <= ovf_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Scan position and pending result
  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    stat_r <= stat_nxt;
    val_r  <= val_nxt;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_min_r <= sacsp_pkg::PULSE_MIN_RST;
      pulse_max_r <= sacsp_pkg::PULSE_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sacsp_pkg::REG_PULSE_MIN: pulse_min_r <= cfg_wdata;
        sacsp_pkg::REG_PULSE_MAX: pulse_max_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load) begin
      out_status_r  <= stat_r;
      out_value_r   <= val_r;
      out_compare_r <= held_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_line_status   = out_status_r;
  assign out_parsed_value  = out_value_r;
  assign out_compare_value = out_compare_r;

endmodule

/* src/sacsp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacsp_checker
// Port-level checks of the result channel of the servo pulse block.
// ----------------------------------------------------------------------------
module sacsp_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [1:0]                      out_line_status,
  input logic signed [15:0]              out_parsed_value,
  input logic [15:0]                     out_compare_value
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_line_status) &&
      $stable(out_parsed_value) && $stable(out_compare_value))
    else $error("stalled result changed");

  // Rejected lines without a number report zero
  a_zero_val: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_line_status == sacsp_pkg::ST_LONG) ||
      (out_line_status == sacsp_pkg::ST_NAN)) |-> out_parsed_value == 16'sd0)
    else $error("nonzero value on a line without a number");

  // Accepted angles lie in 0..180
  a_ok_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_line_status == sacsp_pkg::ST_OK) |->
      (out_parsed_value >= 16'sd0) && (out_parsed_value <= 16'sd180))
    else $error("accepted angle outside 0..180");

  // Out-of-range values lie outside 0..180
  a_bad_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_line_status == sacsp_pkg::ST_RANGE) |->
      (out_parsed_value < 16'sd0) || (out_parsed_value > 16'sd180))
    else $error("out-of-range status on an angle inside 0..180");

endmodule

bind serial_angle_command_to_servo_pulse sacsp_checker u_sacsp_checker (.*);
